// ===== src/tau_pkg.sv =====
// Shared widths, types and helpers for the tile atlas UV lookup.
`default_nettype none

package tau_pkg;

    // Field widths
    localparam int unsigned GID_W      = 20;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned DIM_W      = 15;
    localparam int unsigned SP_W       = 8;
    localparam int unsigned PITCH_W    = 16;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned PIX_W      = 29;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned UV_W       = 18;
    localparam int unsigned QUO_W      = FRAC_W + 1;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    // Border round the atlas, in pixels
    localparam int unsigned MARGIN = 0;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam logic [UV_W-1:0]  UV_MAX  = UV_W'(1) << (FRAC_W + 1);

    // Cell counts: one quotient bit per cell
    localparam int unsigned DIV_CELLS  = CNT_W;
    localparam int unsigned NORM_CELLS = QUO_W;

    // Normalisation lanes
    localparam int unsigned LANES   = 4;
    localparam int unsigned LANE_PX = 0;
    localparam int unsigned LANE_PY = 1;
    localparam int unsigned LANE_TW = 2;
    localparam int unsigned LANE_TH = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_GID    = 3'd0,
        CFG_TILE_COUNT   = 3'd1,
        CFG_COLUMNS      = 3'd2,
        CFG_TILE_WIDTH   = 3'd3,
        CFG_TILE_HEIGHT  = 3'd4,
        CFG_SPACING      = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic in_range;
    } t_front_side;

    typedef struct packed {
        logic             in_range;
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_back_side;

    typedef struct packed {
        logic             sat;
        logic [DIM_W-1:0] rem;
        logic [QUO_W-1:0] acc;
    } t_norm_lane;

    typedef t_norm_lane [LANES-1:0]       t_lanes;
    typedef logic [LANES-1:0][DIM_W-1:0] t_lane_divs;

    typedef struct packed {
        logic             in_range;
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [UV_W-1:0]  u_coord;
        logic [UV_W-1:0]  v_coord;
        logic [UV_W-1:0]  u_size;
        logic [UV_W-1:0]  v_size;
    } t_result;

    // Set up a lane: saturate once value reaches twice the divisor, else
    // preload the remainder with value/2 and shift the last bit in first.
    function automatic t_norm_lane f_lane_init(input logic [PROD_W-1:0] value,
                                               input logic [DIM_W-1:0]  dim);
        t_norm_lane lane;
        lane.sat = (value >= PROD_W'({dim, 1'b0}));
        lane.rem = lane.sat ? '0 : value[DIM_W:1];
        lane.acc = {value[0], {FRAC_W{1'b0}}};
        return lane;
    endfunction

    function automatic logic [UV_W-1:0] f_lane_result(input t_norm_lane lane);
        return lane.sat ? UV_MAX : {1'b0, lane.acc};
    endfunction

    function automatic logic [PIX_W-1:0] f_sat_pix(input logic [PROD_W-1:0] value);
        return (|value[PROD_W-1:PIX_W]) ? PIX_MAX : value[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/tau_in_if.sv =====
// Request channel carrying the global tile id.
`default_nettype none

interface tau_in_if import tau_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [GID_W-1:0] global_id;

    modport source (output valid, output global_id, input ready);
    modport sink (input valid, input global_id, output ready);
endinterface

`default_nettype wire

// ===== src/tau_out_if.sv =====
// Result channel carrying the tile rectangle in pixels and UV.
`default_nettype none

interface tau_out_if import tau_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             in_range;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [UV_W-1:0]  u_coord;
    logic [UV_W-1:0]  v_coord;
    logic [UV_W-1:0]  u_size;
    logic [UV_W-1:0]  v_size;

    modport source (output valid, output in_range, output pixel_x, output pixel_y,
                    output u_coord, output v_coord, output u_size, output v_size,
                    input ready);
    modport sink (input valid, input in_range, input pixel_x, input pixel_y,
                  input u_coord, input v_coord, input u_size, input v_size,
                  output ready);
endinterface

`default_nettype wire

// ===== src/tau_div_cell.sv =====
// One restoring-division step of the column/row split.
`default_nettype none

module tau_div_cell import tau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_front_side      i_side,
    input  logic [DIM_W-1:0] i_rem,
    input  logic [CNT_W-1:0] i_acc,
    input  logic [DIM_W-1:0] i_div,
    output logic             o_vld,
    output t_front_side      o_side,
    output logic [DIM_W-1:0] o_rem,
    output logic [CNT_W-1:0] o_acc
);

    logic             r_vld;
    t_front_side      r_side;
    logic [DIM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_acc;
    logic [DIM_W-1:0] n_rem;
    logic [CNT_W-1:0] n_acc;
    logic [DIM_W:0]   w_trial;
    logic [DIM_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {i_rem, i_acc[CNT_W-1]};
        w_ge    = (w_trial >= {1'b0, i_div});
        w_diff  = w_trial - {1'b0, i_div};
        n_rem   = w_ge ? w_diff[DIM_W-1:0] : w_trial[DIM_W-1:0];
        n_acc   = {i_acc[CNT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_acc  <= n_acc;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

// ===== src/tau_norm_cell.sv =====
// One quotient bit of the four UV normalisation lanes.
`default_nettype none

module tau_norm_cell import tau_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_vld,
    input  t_back_side i_side,
    input  t_lanes     i_lanes,
    input  t_lane_divs i_divs,
    output logic       o_vld,
    output t_back_side o_side,
    output t_lanes     o_lanes
);

    logic       r_vld;
    t_back_side r_side;
    t_lanes     r_lanes;
    t_lanes     n_lanes;

    always_comb begin
        logic [DIM_W:0] trial;
        logic [DIM_W:0] diff;
        logic           ge;
        for (int l = 0; l < LANES; l++) begin
            trial = {i_lanes[l].rem, i_lanes[l].acc[QUO_W-1]};
            ge    = (trial >= {1'b0, i_divs[l]});
            diff  = trial - {1'b0, i_divs[l]};
            n_lanes[l].sat = i_lanes[l].sat;
            n_lanes[l].rem = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            n_lanes[l].acc = {i_lanes[l].acc[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= i_side;
            r_lanes <= n_lanes;
        end
    end

    assign o_vld   = r_vld;
    assign o_side  = r_side;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

// ===== src/tile_atlas_uv_lookup.sv =====
// Tile atlas lookup: global tile id in, tile rectangle in pixels and UV out.
//
// Channels: i_tile takes one request (a global tile id) per cycle with a
// valid/ready handshake; o_uv returns exactly one result per request, in
// order. Configuration goes through i_cfg_we/i_cfg_idx/i_cfg_data and must
// only be written while no request is in flight.
//
// Throughput: one request per cycle while the skid register is empty. The
// pipeline has 36 register stages, the first of which loads at the
// accepting edge: 16 cells split the local id into column and row (one
// quotient bit each), 17 cells form the 1.16 quotients of the four UV lanes,
// plus the entry register, the multiply register and the lane set-up register.
//
// An id outside the tile set returns in_range low and every other field
// zero. UV values saturate at 2.0; pixel origins saturate at 29 bits.
//
// Reset (synchronous, active low) empties the pipeline and the skid register
// and loads the default configuration. When the receiver stalls, the result
// in the last cell moves into a skid register and the chains stop; i_tile
// ready is low only while that skid register is full.
`default_nettype none

module tile_atlas_uv_lookup import tau_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tau_in_if.sink                i_tile,
    tau_out_if.source             o_uv
);

    // Configuration registers
    logic [GID_W-1:0] r_first_gid;
    logic [CNT_W-1:0] r_tile_count;
    logic [DIM_W-1:0] r_columns;
    logic [DIM_W-1:0] r_tile_width;
    logic [DIM_W-1:0] r_tile_height;
    logic [SP_W-1:0]  r_spacing;
    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;

    // Zero divisors count as one
    logic [DIM_W-1:0] w_cols;
    logic [DIM_W-1:0] w_img_w;
    logic [DIM_W-1:0] w_img_h;

    logic w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_gid    <= GID_W'(1);
            r_tile_count   <= '0;
            r_columns      <= DIM_W'(1);
            r_tile_width   <= DIM_W'(16);
            r_tile_height  <= DIM_W'(16);
            r_spacing      <= '0;
            r_image_width  <= DIM_W'(256);
            r_image_height <= DIM_W'(256);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_GID:    r_first_gid    <= i_cfg_data[GID_W-1:0];
                CFG_TILE_COUNT:   r_tile_count   <= i_cfg_data[CNT_W-1:0];
                CFG_COLUMNS:      r_columns      <= i_cfg_data[DIM_W-1:0];
                CFG_TILE_WIDTH:   r_tile_width   <= i_cfg_data[DIM_W-1:0];
                CFG_TILE_HEIGHT:  r_tile_height  <= i_cfg_data[DIM_W-1:0];
                CFG_SPACING:      r_spacing      <= i_cfg_data[SP_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cols  = (r_columns == '0)      ? DIM_W'(1) : r_columns;
    assign w_img_w = (r_image_width == '0)  ? DIM_W'(1) : r_image_width;
    assign w_img_h = (r_image_height == '0) ? DIM_W'(1) : r_image_height;

    // ------------------------------------------------------------------
    // Entry: range check and local id
    // ------------------------------------------------------------------
    logic [GID_W:0]   w_diff;
    logic             w_in_range;
    logic             r_f_vld;
    t_front_side      r_f_side;
    logic [CNT_W-1:0] r_f_local;

    assign w_diff     = {1'b0, i_tile.global_id} - {1'b0, r_first_gid};
    assign w_in_range = !w_diff[GID_W] &&
                        (w_diff[GID_W-1:0] < GID_W'(r_tile_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= i_tile.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_side.in_range <= w_in_range;
            r_f_local         <= w_diff[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Column/row split: local = row * columns + col
    // ------------------------------------------------------------------
    logic             div_vld  [0:DIV_CELLS];
    t_front_side      div_side [0:DIV_CELLS];
    logic [DIM_W-1:0] div_rem  [0:DIV_CELLS];
    logic [CNT_W-1:0] div_acc  [0:DIV_CELLS];

    assign div_vld[0]  = r_f_vld;
    assign div_side[0] = r_f_side;
    assign div_rem[0]  = '0;
    assign div_acc[0]  = r_f_local;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        tau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (div_vld[g]),
            .i_side  (div_side[g]),
            .i_rem   (div_rem[g]),
            .i_acc   (div_acc[g]),
            .i_div   (w_cols),
            .o_vld   (div_vld[g+1]),
            .o_side  (div_side[g+1]),
            .o_rem   (div_rem[g+1]),
            .o_acc   (div_acc[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Pixel origin: margin + index * (tile size + spacing)
    // ------------------------------------------------------------------
    logic [PITCH_W-1:0]       w_pitch_x;
    logic [PITCH_W-1:0]       w_pitch_y;
    logic [DIM_W+PITCH_W-1:0] w_prod_x;
    logic [PROD_W-1:0]        w_prod_y;
    logic                     r_m_vld;
    logic                     r_m_in_range;
    logic [PROD_W-1:0]        r_m_px;
    logic [PROD_W-1:0]        r_m_py;

    assign w_pitch_x = {1'b0, r_tile_width}  + PITCH_W'(r_spacing);
    assign w_pitch_y = {1'b0, r_tile_height} + PITCH_W'(r_spacing);
    assign w_prod_x  = {{PITCH_W{1'b0}}, div_rem[DIV_CELLS]} *
                       {{DIM_W{1'b0}}, w_pitch_x};
    assign w_prod_y  = {{PITCH_W{1'b0}}, div_acc[DIV_CELLS]} *
                       {{CNT_W{1'b0}}, w_pitch_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= div_vld[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_in_range <= div_side[DIV_CELLS].in_range;
            r_m_px       <= PROD_W'(w_prod_x) + PROD_W'(MARGIN);
            r_m_py       <= w_prod_y + PROD_W'(MARGIN);
        end
    end

    // ------------------------------------------------------------------
    // Lane set-up: saturation test and remainder preload
    // ------------------------------------------------------------------
    logic       r_p_vld;
    t_back_side r_p_side;
    t_lanes     r_p_lanes;
    t_lane_divs w_divs;

    assign w_divs[LANE_PX] = w_img_w;
    assign w_divs[LANE_PY] = w_img_h;
    assign w_divs[LANE_TW] = w_img_w;
    assign w_divs[LANE_TH] = w_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_side.in_range  <= r_m_in_range;
            r_p_side.pixel_x   <= f_sat_pix(r_m_px);
            r_p_side.pixel_y   <= f_sat_pix(r_m_py);
            r_p_lanes[LANE_PX] <= f_lane_init(r_m_px, w_img_w);
            r_p_lanes[LANE_PY] <= f_lane_init(r_m_py, w_img_h);
            r_p_lanes[LANE_TW] <= f_lane_init(PROD_W'(r_tile_width), w_img_w);
            r_p_lanes[LANE_TH] <= f_lane_init(PROD_W'(r_tile_height), w_img_h);
        end
    end

    // ------------------------------------------------------------------
    // UV normalisation: value * 2^16 / image size, one bit per cell
    // ------------------------------------------------------------------
    logic       nrm_vld   [0:NORM_CELLS];
    t_back_side nrm_side  [0:NORM_CELLS];
    t_lanes     nrm_lanes [0:NORM_CELLS];

    assign nrm_vld[0]   = r_p_vld;
    assign nrm_side[0]  = r_p_side;
    assign nrm_lanes[0] = r_p_lanes;

    for (genvar g = 0; g < NORM_CELLS; g++) begin : g_norm
        tau_norm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (nrm_vld[g]),
            .i_side  (nrm_side[g]),
            .i_lanes (nrm_lanes[g]),
            .i_divs  (w_divs),
            .o_vld   (nrm_vld[g+1]),
            .o_side  (nrm_side[g+1]),
            .o_lanes (nrm_lanes[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Result assembly and skid register
    // ------------------------------------------------------------------
    t_result w_res;
    t_result r_skid;
    logic    r_skid_vld;
    logic    w_last_vld;
    t_result w_out;

    assign w_last_vld = nrm_vld[NORM_CELLS];

    always_comb begin
        w_res = '0;
        if (nrm_side[NORM_CELLS].in_range) begin
            w_res.in_range = 1'b1;
            w_res.pixel_x  = nrm_side[NORM_CELLS].pixel_x;
            w_res.pixel_y  = nrm_side[NORM_CELLS].pixel_y;
            w_res.u_coord  = f_lane_result(nrm_lanes[NORM_CELLS][LANE_PX]);
            w_res.v_coord  = f_lane_result(nrm_lanes[NORM_CELLS][LANE_PY]);
            w_res.u_size   = f_lane_result(nrm_lanes[NORM_CELLS][LANE_TW]);
            w_res.v_size   = f_lane_result(nrm_lanes[NORM_CELLS][LANE_TH]);
        end
    end

    // Advance the chains whenever the skid register is free
    assign w_en = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_uv.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_last_vld && !o_uv.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Park the stalled result; the chains then hold the next one
    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && w_last_vld && !o_uv.ready) begin
            r_skid <= w_res;
        end
    end

    assign w_out = r_skid_vld ? r_skid : w_res;

    assign i_tile.ready  = w_en;
    assign o_uv.valid    = r_skid_vld || w_last_vld;
    assign o_uv.in_range = w_out.in_range;
    assign o_uv.pixel_x  = w_out.pixel_x;
    assign o_uv.pixel_y  = w_out.pixel_y;
    assign o_uv.u_coord  = w_out.u_coord;
    assign o_uv.v_coord  = w_out.v_coord;
    assign o_uv.u_size   = w_out.u_size;
    assign o_uv.v_size   = w_out.v_size;

endmodule

`default_nettype wire

// ===== tb/sv/tile_atlas_uv_lookup_checker.sv =====
// Checker for the tile atlas lookup: mirrors the registers, predicts each rectangle, compares.
module tile_atlas_uv_lookup_checker import tau_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tau_in_if                     i_tile,
    tau_out_if                    i_uv,
    output int                    o_pending,
    output int                    o_mismatches
);

    typedef struct packed {
        logic [GID_W-1:0] first_gid;
        logic [CNT_W-1:0] tile_count;
        logic [DIM_W-1:0] columns;
        logic [DIM_W-1:0] tile_width;
        logic [DIM_W-1:0] tile_height;
        logic [SP_W-1:0]  spacing;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } atlas_regs_t;

    localparam atlas_regs_t REGS_AT_RESET = '{20'd1, 16'd0, 15'd1, 15'd16, 15'd16,
                                              8'd0, 15'd256, 15'd256};

    atlas_regs_t regs = REGS_AT_RESET;
    t_result     rect_expected[$];
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [PIX_W-1:0] clamp_pixel(input logic [63:0] p);
        return (p > 64'(PIX_MAX)) ? PIX_MAX : p[PIX_W-1:0];
    endfunction

    // floor(value * 2^16 / dim), zero dim counts as one, capped at 2.0
    function automatic logic [UV_W-1:0] norm_1p16(input logic [63:0]      value,
                                                  input logic [DIM_W-1:0] dim);
        logic [63:0] d;
        logic [63:0] q;
        d = (dim == '0) ? 64'd1 : 64'(dim);
        q = (value << FRAC_W) / d;
        return (q > 64'(UV_MAX)) ? UV_MAX : q[UV_W-1:0];
    endfunction

    function automatic t_result lookup_tile(input logic [GID_W-1:0] gid);
        t_result     r;
        logic [63:0] offset;
        logic [63:0] cols;
        logic [63:0] px;
        logic [63:0] py;
        r = '0;
        if (gid < regs.first_gid) return r;
        offset = 64'(gid) - 64'(regs.first_gid);
        if (offset >= 64'(regs.tile_count)) return r;
        cols = (regs.columns == '0) ? 64'd1 : 64'(regs.columns);
        px = 64'(MARGIN) + (offset % cols) * (64'(regs.tile_width) + 64'(regs.spacing));
        py = 64'(MARGIN) + (offset / cols) * (64'(regs.tile_height) + 64'(regs.spacing));
        r.in_range = 1'b1;
        r.pixel_x  = clamp_pixel(px);
        r.pixel_y  = clamp_pixel(py);
        r.u_coord  = norm_1p16(px, regs.image_width);
        r.v_coord  = norm_1p16(py, regs.image_height);
        r.u_size   = norm_1p16(64'(regs.tile_width), regs.image_width);
        r.v_size   = norm_1p16(64'(regs.tile_height), regs.image_height);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            regs = REGS_AT_RESET;
            rect_expected.delete();
        end else begin
            // compare before predicting: a result never belongs to a request of this edge
            if (i_uv.valid && i_uv.ready) begin
                if (rect_expected.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = rect_expected.pop_front();
                    check_field("in_range", 32'(want.in_range), 32'(i_uv.in_range));
                    check_field("pixel_x", 32'(want.pixel_x), 32'(i_uv.pixel_x));
                    check_field("pixel_y", 32'(want.pixel_y), 32'(i_uv.pixel_y));
                    check_field("u_coord", 32'(want.u_coord), 32'(i_uv.u_coord));
                    check_field("v_coord", 32'(want.v_coord), 32'(i_uv.v_coord));
                    check_field("u_size", 32'(want.u_size), 32'(i_uv.u_size));
                    check_field("v_size", 32'(want.v_size), 32'(i_uv.v_size));
                end
            end
            if (i_tile.valid && i_tile.ready)
                rect_expected = {rect_expected, lookup_tile(i_tile.global_id)};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_GID:    regs.first_gid    = i_cfg_data[GID_W-1:0];
                    CFG_TILE_COUNT:   regs.tile_count   = i_cfg_data[CNT_W-1:0];
                    CFG_COLUMNS:      regs.columns      = i_cfg_data[DIM_W-1:0];
                    CFG_TILE_WIDTH:   regs.tile_width   = i_cfg_data[DIM_W-1:0];
                    CFG_TILE_HEIGHT:  regs.tile_height  = i_cfg_data[DIM_W-1:0];
                    CFG_SPACING:      regs.spacing      = i_cfg_data[SP_W-1:0];
                    CFG_IMAGE_WIDTH:  regs.image_width  = i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: regs.image_height = i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= rect_expected.size();
    end

endmodule

// ===== tb/sv/tile_atlas_uv_lookup_tb.sv =====
// Testbench top for the tile atlas lookup: clock, reset, requests, register writes, verdict.
module tile_atlas_uv_lookup_tb;
    import tau_pkg::*;

    // Pacing of the run
    localparam int RANDOM_PHASES    = 14;
    localparam int ITEMS_PER_PHASE  = 125;
    localparam int LONG_HOLD_AT     = 530;   // early in a phase, so requests keep coming
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL       = 40;    // a little over the pipeline latency
    localparam int QUIET_LIMIT      = 3000;  // longest legal stretch is the long hold

    typedef struct packed {
        logic [GID_W-1:0] first_gid;
        logic [CNT_W-1:0] tile_count;
        logic [DIM_W-1:0] columns;
        logic [DIM_W-1:0] tile_width;
        logic [DIM_W-1:0] tile_height;
        logic [SP_W-1:0]  spacing;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } atlas_setup_t;

    logic                  i_clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending_results;
    int                    mismatches;
    int                    requests_sent = 0;
    int                    burst_left = 0;
    logic [GID_W-1:0]      directed_ids[$];

    tau_in_if  tile_if ();
    tau_out_if uv_if ();

    tile_atlas_uv_lookup dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_tile     (tile_if),
        .o_uv       (uv_if)
    );

    tile_atlas_uv_lookup_checker rect_check (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_tile       (tile_if),
        .i_uv         (uv_if),
        .o_pending    (pending_results),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly a value from the usual range; now and then zero or all ones
    function automatic int unsigned pick_value(input int unsigned wid, input int unsigned lo,
                                               input int unsigned hi);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return (32'd1 << wid) - 1;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic atlas_setup_t random_setup();
        atlas_setup_t s;
        s.first_gid    = GID_W'(pick_value(GID_W, 0, (1 << GID_W) - 1));
        s.tile_count   = CNT_W'(pick_value(CNT_W, 1, 3000));
        s.columns      = DIM_W'(pick_value(DIM_W, 1, 64));
        s.tile_width   = DIM_W'(pick_value(DIM_W, 1, 128));
        s.tile_height  = DIM_W'(pick_value(DIM_W, 1, 128));
        s.spacing      = SP_W'(pick_value(SP_W, 0, 255));
        s.image_width  = DIM_W'(pick_value(DIM_W, 16, 4096));
        s.image_height = DIM_W'(pick_value(DIM_W, 16, 4096));
        return s;
    endfunction

    // Mostly ids inside the set, some on its edges, the rest anywhere
    function automatic logic [GID_W-1:0] next_global_id(input atlas_setup_t s);
        int unsigned base;
        int unsigned span;
        base = s.first_gid;
        span = s.tile_count;
        case ($urandom_range(0, 9))
            0, 1: return GID_W'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return GID_W'(base - 1);
                    1:       return GID_W'(base);
                    2:       return GID_W'(base + span - 1);
                    default: return GID_W'(base + span);
                endcase
            end
            default: begin
                if (span == 0) return GID_W'($urandom);
                return GID_W'(base + $urandom_range(0, span - 1));
            end
        endcase
    endfunction

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Write every register back to back, then drop the write enable
    task automatic write_setup(input atlas_setup_t s);
        put_reg(CFG_FIRST_GID, CFG_DATA_W'(s.first_gid));
        put_reg(CFG_TILE_COUNT, CFG_DATA_W'(s.tile_count));
        put_reg(CFG_COLUMNS, CFG_DATA_W'(s.columns));
        put_reg(CFG_TILE_WIDTH, CFG_DATA_W'(s.tile_width));
        put_reg(CFG_TILE_HEIGHT, CFG_DATA_W'(s.tile_height));
        put_reg(CFG_SPACING, CFG_DATA_W'(s.spacing));
        put_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(s.image_width));
        put_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(s.image_height));
        cfg_we <= 1'b0;
    endtask

    // Offer one request and hold it until the block takes it. Between bursts,
    // drop valid for a random gap; a long burst now and then gives stretches
    // with no idling at all.
    task automatic offer_id(input logic [GID_W-1:0] gid);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                tile_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        tile_if.valid     <= 1'b1;
        tile_if.global_id <= gid;
        do @(posedge i_clk); while (!tile_if.ready);
        requests_sent++;
    endtask

    // Stop offering and wait until every request has come back. The count from
    // the checker is registered, so wait for the next edge before looking at it.
    task automatic drain_results();
        tile_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic run_directed(input atlas_setup_t s);
        drain_results();
        write_setup(s);
        foreach (directed_ids[k]) offer_id(directed_ids[k]);
    endtask

    // Stimulus
    initial begin
        atlas_setup_t s;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_FIRST_GID;
        cfg_data          <= '0;
        tile_if.valid     <= 1'b0;
        tile_if.global_id <= '0;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setup has an empty set: nothing may come back in range
        offer_id(GID_W'(0));
        offer_id(GID_W'(1));
        offer_id({GID_W{1'b1}});

        // Small set: both edges of the set, either side of them, a row wrap
        s = '{20'd100, 16'd50, 15'd8, 15'd16, 15'd16, 8'd2, 15'd256, 15'd128};
        directed_ids = '{GID_W'(99), GID_W'(100), GID_W'(149), GID_W'(150),
                         GID_W'(107), GID_W'(108), GID_W'(0), {GID_W{1'b1}}};
        run_directed(s);

        // Zero columns and zero image width count as one; zero tile height
        s = '{20'd0, 16'hFFFF, 15'd0, 15'h7FFF, 15'd0, 8'hFF, 15'd0, 15'h7FFF};
        directed_ids = '{GID_W'(0), GID_W'(1), GID_W'(65534), GID_W'(65535)};
        run_directed(s);

        // Widest atlas: UV saturates, pixel origins do not; zero tile width
        s = '{20'd0, 16'hFFFF, 15'h7FFF, 15'd0, 15'h7FFF, 8'hFF, 15'h7FFF, 15'd1};
        directed_ids = '{GID_W'(32766), GID_W'(32767), GID_W'(65534), GID_W'(98304)};
        run_directed(s);

        // Set starting at the top id: only that id is in range
        s = '{20'hFFFFF, 16'hFFFF, 15'd1, 15'd1, 15'd1, 8'd0, 15'h7FFF, 15'h7FFF};
        directed_ids = '{{GID_W{1'b1}}, GID_W'(20'hFFFFE)};
        run_directed(s);

        // Random setups, each one entered only once the block has drained
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s = random_setup();
            drain_results();
            write_setup(s);
            repeat (ITEMS_PER_PHASE) offer_id(next_global_id(s));
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: stall in segments of differing character. Once, well into
    // the run, hold off long enough for the pipeline and skid register to fill
    // so that the block has to stall its request channel.
    initial begin
        int   seg_len;
        int   seg_mode;
        logic rdy;
        bit   long_hold_done;
        long_hold_done = 1'b0;
        uv_if.ready <= 1'b0;
        forever begin
            seg_len  = $urandom_range(4, 60);
            seg_mode = $urandom_range(0, 3);
            for (int k = 0; k < seg_len; k++) begin
                case (seg_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (k % 4) != 3;
                    default: rdy = ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
                uv_if.ready <= rdy;
            end
            if (!long_hold_done && requests_sent >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                @(posedge i_clk);
                uv_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    // Watchdog: give up after too long with no request or result moving
    always @(posedge i_clk) begin
        int quiet;
        if (!rst_n || (tile_if.valid && tile_if.ready) || (uv_if.valid && uv_if.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
src/tau_pkg.sv
src/tau_in_if.sv
src/tau_out_if.sv
src/tau_div_cell.sv
src/tau_norm_cell.sv
src/tile_atlas_uv_lookup.sv
tb/sv/tile_atlas_uv_lookup_checker.sv
tb/sv/tile_atlas_uv_lookup_tb.sv
